/* sv/tbpbx_pkg.sv */
package tbpbx_pkg;

  // Item kinds on the input channel.
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_WAIT_EN  = 4'b0010,
    PH_WAIT_CLK = 4'b0100,
    PH_XFER     = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] send_byte;
    logic       transmit;
    logic       clk_bit0;
    logic       clk_bit1;
    logic       partner_enable;
    logic       in_bit0;
    logic       in_bit1;
  } item_t;

  typedef struct packed {
    logic       drive_bit0;
    logic       drive_bit1;
    logic       drive_enable;
    logic       busy_res;
    logic       done_res;
    logic       aborted;
    logic [7:0] received_byte;
  } result_t;

endpackage

/* sv/tbpbx_if.sv */
interface tbpbx_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] send_byte;
  logic       transmit;
  logic       clk_bit0;
  logic       clk_bit1;
  logic       partner_enable;
  logic       in_bit0;
  logic       in_bit1;

  modport source (
    output valid, kind, send_byte, transmit, clk_bit0, clk_bit1,
           partner_enable, in_bit0, in_bit1,
    input  ready
  );
  modport sink (
    input  valid, kind, send_byte, transmit, clk_bit0, clk_bit1,
           partner_enable, in_bit0, in_bit1,
    output ready
  );
endinterface

interface tbpbx_out_if;
  logic       valid;
  logic       ready;
  logic       drive_bit0;
  logic       drive_bit1;
  logic       drive_enable;
  logic       busy_res;
  logic       done_res;
  logic       aborted;
  logic [7:0] received_byte;

  modport source (
    output valid, drive_bit0, drive_bit1, drive_enable, busy_res, done_res,
           aborted, received_byte,
    input  ready
  );
  modport sink (
    input  valid, drive_bit0, drive_bit1, drive_enable, busy_res, done_res,
           aborted, received_byte,
    output ready
  );
endinterface

/* sv/tbpbx_core.sv */
module tbpbx_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tbpbx_pkg::item_t   item,
  output tbpbx_pkg::result_t res
);

  tbpbx_pkg::phase_t phase_r, phase_nxt;
  logic [1:0] quarter_r, quarter_nxt;
  logic       last_c0_r, last_c0_nxt;
  logic [7:0] send_hold_r, send_hold_nxt;
  logic [7:0] rx_sum_r, rx_sum_nxt;
  logic [2:0] pins_r, pins_nxt;

  logic       both_high;
  logic       do_q;
  logic [1:0] q_use;
  logic       done;
  logic       abrt;
  logic [7:0] rx;

  assign both_high = item.in_bit0 & item.in_bit1;

  always_comb begin
    phase_nxt     = phase_r;
    quarter_nxt   = quarter_r;
    last_c0_nxt   = last_c0_r;
    send_hold_nxt = send_hold_r;
    rx_sum_nxt    = rx_sum_r;
    pins_nxt      = pins_r;
    do_q          = 1'b0;
    q_use         = quarter_r;
    done          = 1'b0;
    abrt          = 1'b0;
    rx            = '0;

    case (item.kind)
      tbpbx_pkg::KIND_START: begin
        send_hold_nxt = item.send_byte;
        rx_sum_nxt    = '0;
        quarter_nxt   = '0;
        last_c0_nxt   = 1'b0;
        pins_nxt[2]   = item.transmit;
        phase_nxt     = tbpbx_pkg::PH_WAIT_EN;
      end
      default: begin
        unique case (phase_r) inside
          tbpbx_pkg::PH_WAIT_EN, tbpbx_pkg::PH_WAIT_CLK: begin
            if (phase_r == tbpbx_pkg::PH_WAIT_EN && !item.partner_enable) begin
              if (both_high) begin
                abrt      = 1'b1;
                done      = 1'b1;
                phase_nxt = tbpbx_pkg::PH_IDLE;
              end
            end else if (item.clk_bit0 || item.clk_bit1) begin
              if (both_high) begin
                abrt      = 1'b1;
                done      = 1'b1;
                phase_nxt = tbpbx_pkg::PH_IDLE;
              end else begin
                phase_nxt = tbpbx_pkg::PH_WAIT_CLK;
              end
            end else begin
              // Clock is at 00: the first quarter starts on this item.
              phase_nxt   = tbpbx_pkg::PH_XFER;
              quarter_nxt = '0;
              q_use       = '0;
              do_q        = 1'b1;
            end
          end
          tbpbx_pkg::PH_XFER: begin
            if (item.clk_bit0 != last_c0_r) begin
              quarter_nxt = {item.clk_bit1, item.clk_bit0};
              q_use       = {item.clk_bit1, item.clk_bit0};
              if (q_use == 2'd0) begin
                done        = 1'b1;
                rx          = rx_sum_r;
                pins_nxt[2] = 1'b0;
                phase_nxt   = tbpbx_pkg::PH_IDLE;
              end else begin
                do_q = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    endcase

    // Drive the pair for this quarter and fold the received pair into the sum.
    if (do_q) begin
      pins_nxt[1:0] = send_hold_r[{q_use, 1'b0} +: 2];
      if (item.partner_enable) begin
        rx_sum_nxt = rx_sum_r + ({6'd0, item.in_bit1, item.in_bit0} << {q_use, 1'b0});
      end
      last_c0_nxt = item.clk_bit0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tbpbx_pkg::PH_IDLE;
      quarter_r   <= '0;
      last_c0_r   <= 1'b0;
      send_hold_r <= '0;
      rx_sum_r    <= '0;
      pins_r      <= '0;
    end else if (en) begin
      phase_r     <= phase_nxt;
      quarter_r   <= quarter_nxt;
      last_c0_r   <= last_c0_nxt;
      send_hold_r <= send_hold_nxt;
      rx_sum_r    <= rx_sum_nxt;
      pins_r      <= pins_nxt;
    end
  end

  always_comb begin
    res.drive_bit0    = pins_nxt[0];
    res.drive_bit1    = pins_nxt[1];
    res.drive_enable  = pins_nxt[2];
    res.busy_res      = (phase_nxt != tbpbx_pkg::PH_IDLE);
    res.done_res      = done;
    res.aborted       = abrt;
    res.received_byte = rx;
  end

`ifndef SYNTHESIS
  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    en && res.done_res |=> phase_r == tbpbx_pkg::PH_IDLE)
    else $error("exchange ended but block did not return to idle");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.kind == tbpbx_pkg::KIND_START
    |=> phase_r == tbpbx_pkg::PH_WAIT_EN && rx_sum_r == 8'd0 && quarter_r == 2'd0)
    else $error("start item did not reset the exchange");

  a_abort_clean: assert property (@(posedge clk) disable iff (!rst_n)
    en && res.aborted |-> res.done_res && res.received_byte == 8'd0)
    else $error("aborted exchange reported data or no end");

  a_idle_sample_holds: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.kind == tbpbx_pkg::KIND_SAMPLE && phase_r == tbpbx_pkg::PH_IDLE
    |=> phase_r == tbpbx_pkg::PH_IDLE && $stable(pins_r) && $stable(rx_sum_r))
    else $error("sample while idle changed state");
`endif

endmodule

/* sv/two_bit_parallel_byte_exchange.sv */
// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   kind, send_byte, transmit, clk_bit0/1, partner_enable, in_bit0/1
// out_ch   out  valid/ready   drive_bit0/1, drive_enable, busy_res, done_res, aborted,
//                             received_byte
//
// One item is accepted per cycle unless both registers are full.
// An input register feeds the protocol step, whose result lands in the output register.
// Reset (rst_n low, synchronous) returns the exchange to idle with its pin state cleared.
// A stalled output holds its result; the input keeps accepting until both registers fill.
module two_bit_parallel_byte_exchange (
  input logic          clk,
  input logic          rst_n,
  tbpbx_in_if.sink     in_ch,
  tbpbx_out_if.source  out_ch
);

  logic                s1_valid_r;
  tbpbx_pkg::item_t    s1_item_r;
  logic                out_valid_r;
  tbpbx_pkg::result_t  out_res_r;
  tbpbx_pkg::result_t  core_res;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.kind           <= in_ch.kind;
      s1_item_r.send_byte      <= in_ch.send_byte;
      s1_item_r.transmit       <= in_ch.transmit;
      s1_item_r.clk_bit0       <= in_ch.clk_bit0;
      s1_item_r.clk_bit1       <= in_ch.clk_bit1;
      s1_item_r.partner_enable <= in_ch.partner_enable;
      s1_item_r.in_bit0        <= in_ch.in_bit0;
      s1_item_r.in_bit1        <= in_ch.in_bit1;
    end
    if (s1_fire) begin
      out_res_r <= core_res;
    end
  end

  tbpbx_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_fire),
    .item  (s1_item_r),
    .res   (core_res)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive_bit0    = out_res_r.drive_bit0;
  assign out_ch.drive_bit1    = out_res_r.drive_bit1;
  assign out_ch.drive_enable  = out_res_r.drive_enable;
  assign out_ch.busy_res      = out_res_r.busy_res;
  assign out_ch.done_res      = out_res_r.done_res;
  assign out_ch.aborted       = out_res_r.aborted;
  assign out_ch.received_byte = out_res_r.received_byte;

endmodule
